// ===== rtl/core/chtab_pkg.sv =====
// Shared constants and codes of the chained hash table.
package chtab_pkg;

   localparam int DEF_MAX_BUCKETS = 256;
   localparam int DEF_MAX_ENTRIES = 256;

   localparam int CMD_W    = 3;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;
   localparam int CSR_W    = 9;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT      = 3'd0,
      CMD_LOOKUP      = 3'd1,
      CMD_LOOKUP_PAIR = 3'd2,
      CMD_REMOVE      = 3'd3,
      CMD_REMOVE_PAIR = 3'd4,
      CMD_FLUSH       = 3'd5
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

endpackage

// ===== rtl/core/chtab_mod.sv =====
// Iterative remainder unit: 32-bit dividend, two quotient bits per cycle.
module chtab_mod #(
   parameter int DIV_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] remainder
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [31:0]      dvd_ff, dvd_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] rem_one, rem_two;

   // One restoring step: shift in a dividend bit and subtract the divisor if it fits.
   function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0] r, input logic b,
                                                 input logic [DIV_W-1:0] d);
      logic [DIV_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[DIV_W-1:0];
   endfunction

   assign rem_one = rem_step(rem_ff, dvd_ff[31], dsr_ff);
   assign rem_two = rem_step(rem_one, dvd_ff[30], dsr_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_two;
         dvd_in = {dvd_ff[29:0], 2'b00};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/chained_hash_table_top.sv =====
// Top level of the chained hash table: command front end, bucket and node memories.
//
// Key-value store with separate chaining. Each command word returns exactly one result
// word. The bucket of a key is the key modulo the bucket count, which the remainder unit
// works out at two bits per cycle in 16 steps before it hands the remainder over. An
// insert then reads the bucket head and the link of the free node and puts the new node
// at the head of the chain. A lookup reads the bucket head and then walks the chain,
// and a remove also returns the found node to the free list; the chain walk through the
// node memory, one node per cycle, is what makes these commands vary in length. A flush,
// and likewise the start-up after reset, sweeps both memories one entry per cycle; no
// command word is accepted during that sweep. Unused command codes answer "not found".
// One command is in work at a time, but the next word is taken while a result still
// waits on the response side. The bucket count may be written only while the block is
// idle; zero is taken as one and values above MAX_BUCKETS as MAX_BUCKETS.
module chained_hash_table_top #(
   parameter int MAX_BUCKETS = chtab_pkg::DEF_MAX_BUCKETS,
   parameter int MAX_ENTRIES = chtab_pkg::DEF_MAX_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request words: command [2:0], key [34:3], value [66:35], zero fill above.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [chtab_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Response words: status [1:0], found_value [33:2], entry_count [42:34], zero fill above.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [chtab_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Bucket count register.
   input  logic                              csr_we,
   input  logic [chtab_pkg::CSR_W-1:0]       csr_wdata
);

   // Node links carry one code beyond the last node to mean "no node".
   localparam int EW   = $clog2(MAX_ENTRIES + 1);
   localparam int IW   = $clog2(MAX_ENTRIES);
   localparam int BW   = $clog2(MAX_BUCKETS);
   localparam int DW   = $clog2(MAX_BUCKETS + 1);
   localparam int MAXN = (MAX_BUCKETS > MAX_ENTRIES) ? MAX_BUCKETS : MAX_ENTRIES;
   localparam int SW   = $clog2(MAXN);
   localparam int KVW  = chtab_pkg::KEY_W + chtab_pkg::VAL_W;
   localparam logic [EW-1:0] NIL = EW'(MAX_ENTRIES);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_DIV   = 7'b0000100,
      S_HEAD  = 7'b0001000,
      S_WALK  = 7'b0010000,
      S_FREE  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Memories with one write and one registered read port each.
   logic [EW-1:0]  bucket_mem [MAX_BUCKETS];
   logic [EW-1:0]  next_mem   [MAX_ENTRIES];
   logic [KVW-1:0] kv_mem     [MAX_ENTRIES];

   logic           bh_we, nn_we, kv_we;
   logic [BW-1:0]  bh_waddr, bh_raddr;
   logic [IW-1:0]  nn_waddr, nn_raddr, kv_waddr, kv_raddr;
   logic [EW-1:0]  bh_wdata, nn_wdata, bh_rdata, nn_rdata;
   logic [KVW-1:0] kv_wdata, kv_rdata;

   logic [chtab_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [chtab_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [chtab_pkg::VAL_W-1:0]    val_ff, val_in;
   logic [BW-1:0]                  slot_ff, slot_in;
   logic [EW-1:0]                  cur_ff, cur_in;
   logic [EW-1:0]                  prev_ff, prev_in;
   logic [EW-1:0]                  steps_ff, steps_in;
   logic [EW-1:0]                  free_head_ff, free_head_in;
   logic [EW-1:0]                  count_ff, count_in;
   logic [SW-1:0]                  sweep_ff, sweep_in;
   logic                           flush_ff, flush_in;
   logic [DW-1:0]                  divisor_ff, divisor_in;
   logic [chtab_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [chtab_pkg::VAL_W-1:0]    res_found_ff, res_found_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [chtab_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                           div_start, div_done;
   logic [DW-1:0]                  div_rem;
   logic                           req_fire, pair_cmd, node_hit, full;
   logic [chtab_pkg::CMD_W-1:0]    req_cmd;
   logic [EW-1:0]                  steps_next;

   chtab_mod #(
      .DIV_W(DW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_tdata[34:3]),
      .divisor   (divisor_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (bh_we) begin
         bucket_mem[bh_waddr] <= bh_wdata;
      end
      bh_rdata <= bucket_mem[bh_raddr];
   end

   always_ff @(posedge clock) begin
      if (nn_we) begin
         next_mem[nn_waddr] <= nn_wdata;
      end
      nn_rdata <= next_mem[nn_raddr];
   end

   always_ff @(posedge clock) begin
      if (kv_we) begin
         kv_mem[kv_waddr] <= kv_wdata;
      end
      kv_rdata <= kv_mem[kv_raddr];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = req_tdata[2:0];
   assign full       = (free_head_ff >= NIL) || (count_ff >= NIL);
   assign pair_cmd   = (cmd_ff == chtab_pkg::CMD_LOOKUP_PAIR) ||
                       (cmd_ff == chtab_pkg::CMD_REMOVE_PAIR);
   // The node memory holds the key in the upper half and the value in the lower half.
   assign node_hit   = (kv_rdata[KVW-1:chtab_pkg::VAL_W] == key_ff) &&
                       (!pair_cmd || (kv_rdata[chtab_pkg::VAL_W-1:0] == val_ff));
   assign steps_next = steps_ff + EW'(1);

   // A hashed command starts the remainder unit as it is accepted.
   assign div_start = req_fire && (req_cmd <= chtab_pkg::CMD_REMOVE_PAIR) &&
                      !((req_cmd == chtab_pkg::CMD_INSERT) && full);

   // The bucket count is saturated as it is written, so the divider sees a legal divisor.
   always_comb begin
      divisor_in = divisor_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            divisor_in = DW'(1);
         end else if (32'(csr_wdata) > 32'(MAX_BUCKETS)) begin
            divisor_in = DW'(MAX_BUCKETS);
         end else begin
            divisor_in = DW'(csr_wdata);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      flush_in      = flush_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;

      bh_we    = 1'b0;
      bh_waddr = slot_ff;
      bh_wdata = NIL;
      bh_raddr = slot_ff;
      nn_we    = 1'b0;
      nn_waddr = cur_ff[IW-1:0];
      nn_wdata = free_head_ff;
      nn_raddr = cur_ff[IW-1:0];
      kv_we    = 1'b0;
      kv_waddr = free_head_ff[IW-1:0];
      kv_wdata = {key_ff, val_ff};
      kv_raddr = cur_ff[IW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            // Empty every chain and link node i to node i+1 to rebuild the free list.
            bh_we    = (32'(sweep_ff) < 32'(MAX_BUCKETS));
            bh_waddr = sweep_ff[BW-1:0];
            bh_wdata = NIL;
            nn_we    = (32'(sweep_ff) < 32'(MAX_ENTRIES));
            nn_waddr = sweep_ff[IW-1:0];
            nn_wdata = EW'(32'(sweep_ff) + 32'd1);
            sweep_in = sweep_ff + SW'(1);
            if (32'(sweep_ff) == 32'(MAXN - 1)) begin
               sweep_in     = '0;
               free_head_in = '0;
               count_in     = '0;
               flush_in     = 1'b0;
               if (flush_ff) begin
                  res_status_in = chtab_pkg::STATUS_OK;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_cmd;
               key_in        = req_tdata[34:3];
               val_in        = req_tdata[66:35];
               res_status_in = chtab_pkg::STATUS_NOT_FOUND;
               res_found_in  = '0;
               if (req_cmd == chtab_pkg::CMD_FLUSH) begin
                  flush_in = 1'b1;
                  state_in = S_CLEAR;
               end else if (req_cmd > chtab_pkg::CMD_FLUSH) begin
                  state_in = S_RESP;
               end else if ((req_cmd == chtab_pkg::CMD_INSERT) && full) begin
                  res_status_in = chtab_pkg::STATUS_FULL;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_DIV;
               end
            end
         end

         S_DIV: begin
            // Read the bucket head, and the link of the free node for an insert.
            if (div_done) begin
               slot_in  = div_rem[BW-1:0];
               bh_raddr = div_rem[BW-1:0];
               nn_raddr = free_head_ff[IW-1:0];
               state_in = S_HEAD;
            end
         end

         S_HEAD: begin
            if (cmd_ff == chtab_pkg::CMD_INSERT) begin
               kv_we         = 1'b1;
               kv_waddr      = free_head_ff[IW-1:0];
               nn_we         = 1'b1;
               nn_waddr      = free_head_ff[IW-1:0];
               nn_wdata      = bh_rdata;
               bh_we         = 1'b1;
               bh_wdata      = free_head_ff;
               free_head_in  = nn_rdata;
               count_in      = count_ff + EW'(1);
               res_status_in = chtab_pkg::STATUS_OK;
               state_in      = S_RESP;
            end else if (bh_rdata >= NIL) begin
               state_in = S_RESP;
            end else begin
               kv_raddr = bh_rdata[IW-1:0];
               nn_raddr = bh_rdata[IW-1:0];
               cur_in   = bh_rdata;
               prev_in  = NIL;
               steps_in = '0;
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            if (node_hit) begin
               res_status_in = chtab_pkg::STATUS_OK;
               res_found_in  = kv_rdata[chtab_pkg::VAL_W-1:0];
               if ((cmd_ff == chtab_pkg::CMD_REMOVE) ||
                   (cmd_ff == chtab_pkg::CMD_REMOVE_PAIR)) begin
                  // Unlink the node from its predecessor or from the bucket head.
                  if (prev_ff >= NIL) begin
                     bh_we    = 1'b1;
                     bh_wdata = nn_rdata;
                  end else begin
                     nn_we    = 1'b1;
                     nn_waddr = prev_ff[IW-1:0];
                     nn_wdata = nn_rdata;
                  end
                  state_in = S_FREE;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               prev_in  = cur_ff;
               cur_in   = nn_rdata;
               steps_in = steps_next;
               if ((nn_rdata >= NIL) || (steps_next == NIL)) begin
                  state_in = S_RESP;
               end else begin
                  kv_raddr = nn_rdata[IW-1:0];
                  nn_raddr = nn_rdata[IW-1:0];
               end
            end
         end

         S_FREE: begin
            // The removed node goes to the front of the free list.
            nn_we        = 1'b1;
            nn_waddr     = cur_ff[IW-1:0];
            nn_wdata     = free_head_ff;
            free_head_in = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - EW'(1);
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loaded when the result is ready and the previous word has gone.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b00000, chtab_pkg::COUNT_W'(count_ff), res_found_ff,
                         res_status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         flush_ff     <= 1'b0;
         free_head_ff <= '0;
         count_ff     <= '0;
         divisor_ff   <= DW'(MAX_BUCKETS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         flush_ff     <= flush_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         divisor_ff   <= divisor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sim/chained_hash_table_top_test.sv =====
// Self-checking simulation of the chained hash table with random traffic and stalls.
module chained_hash_table_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBUCKETS = chtab_pkg::DEF_MAX_BUCKETS;
   localparam int NENTRIES = chtab_pkg::DEF_MAX_ENTRIES;
   localparam int NIL      = NENTRIES;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] key;
      logic [31:0] value;
   } command_word_type;

   // Packed from the top bit down, so the status lands in the lowest bits.
   typedef struct packed {
      logic [8:0]  entry_count;
      logic [31:0] found_value;
      logic [1:0]  status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [chtab_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [chtab_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [chtab_pkg::CSR_W-1:0] csr_wdata = '0;

   chained_hash_table_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the table, kept in step with every accepted command word.
   logic [8:0]  shadow_buckets;
   logic [8:0]  shadow_head [NBUCKETS];
   logic [31:0] shadow_key  [NENTRIES];
   logic [31:0] shadow_value[NENTRIES];
   logic [8:0]  shadow_next [NENTRIES];
   logic [8:0]  shadow_free;
   logic [8:0]  shadow_total;

   command_word_type pending_words[$];
   answer_type       expected_answers[$];
   int mismatches = 0;
   int accepted_words = 0;
   int checked_answers = 0;
   int full_answers = 0;
   int hit_answers = 0;
   bit sender_paused = 1'b0;

   function automatic void clear_shadow();
      for (int i = 0; i < NBUCKETS; i++) shadow_head[i] = 9'(NIL);
      for (int i = 0; i < NENTRIES; i++) shadow_next[i] = 9'(i + 1);
      shadow_free  = '0;
      shadow_total = '0;
   endfunction

   function automatic int bucket_of(logic [31:0] key);
      int n;
      n = int'(shadow_buckets);
      if (n == 0) n = 1;
      if (n > NBUCKETS) n = NBUCKETS;
      return int'(key % n);
   endfunction

   // Applies one command to the shadow table and returns the answer it gives.
   function automatic answer_type apply_command(command_word_type w);
      answer_type a;
      int b, node, prior, steps;
      bit hit;
      a.status = chtab_pkg::STATUS_NOT_FOUND;
      a.found_value = '0;
      b = bucket_of(w.key);
      hit = 1'b0;
      prior = NIL;
      node = NIL;
      if (w.cmd inside {chtab_pkg::CMD_LOOKUP, chtab_pkg::CMD_LOOKUP_PAIR,
                        chtab_pkg::CMD_REMOVE, chtab_pkg::CMD_REMOVE_PAIR}) begin
         node = int'(shadow_head[b]);
         steps = 0;
         while (node < NENTRIES && steps < NENTRIES && !hit) begin
            if (shadow_key[node] == w.key && (!(w.cmd inside {chtab_pkg::CMD_LOOKUP_PAIR,
                  chtab_pkg::CMD_REMOVE_PAIR}) || shadow_value[node] == w.value)) begin
               hit = 1'b1;
            end else begin
               prior = node;
               node = int'(shadow_next[node]);
               steps++;
            end
         end
      end
      case (w.cmd) inside
         chtab_pkg::CMD_INSERT: begin
            if (shadow_free >= NENTRIES || shadow_total >= NENTRIES) begin
               a.status = chtab_pkg::STATUS_FULL;
            end else begin
               node = int'(shadow_free);
               shadow_free = shadow_next[node];
               shadow_key[node] = w.key;
               shadow_value[node] = w.value;
               shadow_next[node] = shadow_head[b];
               shadow_head[b] = 9'(node);
               shadow_total++;
               a.status = chtab_pkg::STATUS_OK;
            end
         end
         chtab_pkg::CMD_LOOKUP, chtab_pkg::CMD_LOOKUP_PAIR: begin
            if (hit) begin
               a.status = chtab_pkg::STATUS_OK;
               a.found_value = shadow_value[node];
            end
         end
         chtab_pkg::CMD_REMOVE, chtab_pkg::CMD_REMOVE_PAIR: begin
            if (hit) begin
               a.status = chtab_pkg::STATUS_OK;
               a.found_value = shadow_value[node];
               if (prior >= NENTRIES) shadow_head[b] = shadow_next[node];
               else shadow_next[prior] = shadow_next[node];
               shadow_next[node] = shadow_free;
               shadow_free = 9'(node);
               if (shadow_total > 0) shadow_total--;
            end
         end
         chtab_pkg::CMD_FLUSH: begin
            clear_shadow();
            a.status = chtab_pkg::STATUS_OK;
         end
         default: ;
      endcase
      a.entry_count = shadow_total;
      return a;
   endfunction

   // Driver: bursts of words from the pending queue, separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_words++;
            expected_answers.push_back(apply_command(pending_words.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) gap_left--;
            if (sender_paused || pending_words.size() == 0 || gap_left > 0) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= {5'd0, pending_words[0].value, pending_words[0].key,
                              pending_words[0].cmd};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end
         end
      end
   end

   // Monitor: the receiver stalls in phases that it picks itself.
   int stall_phase = 0;
   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[42:0];
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected response word %h with nothing awaited", rsp_tdata);
            end else begin
               want = expected_answers.pop_front();
               checked_answers++;
               if (got.status == chtab_pkg::STATUS_FULL) full_answers++;
               if (got !== want || rsp_tdata[chtab_pkg::RSP_DATA_W-1:43] !== '0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Response mismatch: status %0d/%0d value %h/%h count %0d/%0d",
                              got.status, want.status, got.found_value, want.found_value,
                              got.entry_count, want.entry_count);
               end else if (want.found_value != 0) begin
                  hit_answers++;
               end
            end
         end
         stall_phase = (stall_phase + 1) % 64;
         if (stall_phase < 16) rsp_tready <= 1'b1;
         else if (stall_phase < 24) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Waits until the block has answered every word handed to it, plus a settling margin.
   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || expected_answers.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_bucket_count(logic [8:0] n);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_buckets = n;
   endtask

   function automatic void queue_word(logic [2:0] cmd, logic [31:0] key, logic [31:0] value);
      command_word_type w;
      w.cmd = cmd;
      w.key = key;
      w.value = value;
      pending_words.push_back(w);
   endfunction

   // Random traffic: inserts mixed with lookups and removals of earlier inserted keys,
   // drawn from a small key set so that chains grow and keys repeat.
   task automatic queue_random(int count, int key_span);
      logic [31:0] used_keys[$];
      logic [31:0] used_values[$];
      logic [31:0] k, v;
      int pick, sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (used_keys.size() > 0 && sel >= 40) begin
            pick = $urandom_range(0, used_keys.size() - 1);
            k = used_keys[pick];
            v = ($urandom_range(0, 3) == 0) ? $urandom() : used_values[pick];
         end else begin
            k = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, key_span);
            v = $urandom();
         end
         if (sel < 40)       queue_word(chtab_pkg::CMD_INSERT, k, v);
         else if (sel < 55)  queue_word(chtab_pkg::CMD_LOOKUP, k, v);
         else if (sel < 68)  queue_word(chtab_pkg::CMD_LOOKUP_PAIR, k, v);
         else if (sel < 82)  queue_word(chtab_pkg::CMD_REMOVE, k, v);
         else if (sel < 95)  queue_word(chtab_pkg::CMD_REMOVE_PAIR, k, v);
         else if (sel < 97)  queue_word(3'($urandom_range(6, 7)), $urandom(), $urandom());
         else if (sel < 98)  queue_word(chtab_pkg::CMD_FLUSH, $urandom(), $urandom());
         else                queue_word(chtab_pkg::CMD_INSERT, $urandom(), $urandom());
         if (sel < 40) begin
            used_keys.push_back(k);
            used_values.push_back(v);
         end
      end
   endtask

   initial begin
      shadow_buckets = 9'(NBUCKETS);
      for (int i = 0; i < NENTRIES; i++) begin
         shadow_key[i] = '0;
         shadow_value[i] = '0;
      end
      clear_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: field extremes, every command, unused codes, colliding keys.
      queue_word(chtab_pkg::CMD_LOOKUP, 32'd0, 32'd0);
      queue_word(chtab_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'd0);
      queue_word(chtab_pkg::CMD_INSERT, 32'd0, 32'hFFFF_FFFF);
      queue_word(chtab_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'd0);
      queue_word(chtab_pkg::CMD_INSERT, 32'd256, 32'h5555_AAAA);
      queue_word(chtab_pkg::CMD_INSERT, 32'd0, 32'hAAAA_5555);
      queue_word(chtab_pkg::CMD_LOOKUP, 32'd0, 32'd0);
      queue_word(chtab_pkg::CMD_LOOKUP_PAIR, 32'd0, 32'hFFFF_FFFF);
      queue_word(chtab_pkg::CMD_LOOKUP_PAIR, 32'd256, 32'd1);
      queue_word(chtab_pkg::CMD_REMOVE_PAIR, 32'd0, 32'hFFFF_FFFF);
      queue_word(chtab_pkg::CMD_REMOVE, 32'd256, 32'd0);
      queue_word(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_word(3'd7, 32'd0, 32'd0);
      queue_word(chtab_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0);
      queue_word(chtab_pkg::CMD_FLUSH, 32'd0, 32'd0);
      queue_word(chtab_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0);
      drain();

      // Fill the pool beyond its capacity so that inserts report a full table.
      write_bucket_count(9'd0);
      for (int i = 0; i < NENTRIES + 3; i++)
         queue_word(chtab_pkg::CMD_INSERT, $urandom(), $urandom());
      queue_word(chtab_pkg::CMD_LOOKUP, 32'h1234_5678, 32'd0);
      queue_word(chtab_pkg::CMD_FLUSH, 32'd0, 32'd0);
      drain();

      // Random phases with different bucket counts, extremes included; the count changes
      // between phases while entries are still held, so that keys are remapped.
      write_bucket_count(9'd1);
      queue_random(140, 40);
      drain();
      write_bucket_count(9'h1FF);
      queue_random(140, 600);
      // Part way through, the sender holds back until every answer is in.
      repeat (400) @(posedge clock);
      sender_paused = 1'b1;
      while (req_tvalid || expected_answers.size() != 0) @(posedge clock);
      sender_paused = 1'b0;
      drain();
      write_bucket_count(9'd7);
      queue_random(135, 60);
      drain();
      write_bucket_count(9'd256);
      queue_random(135, 2000);
      drain();
      write_bucket_count(9'd13);
      queue_random(135, 100);
      drain();
      write_bucket_count(9'd255);
      queue_random(135, 3000);
      queue_word(chtab_pkg::CMD_FLUSH, 32'd0, 32'd0);
      drain();

      $display("Run covered %0d command words and %0d answers, %0d with a value, %0d full.",
               accepted_words, checked_answers, hit_answers, full_answers);
      $display("Bucket counts 0, 1, 7, 13, 255, 256 and 511 were used.");
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #40ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
